### hw/rtl/assert_macros.svh
// shared assertion macros, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence in the cycle after the trigger
`define ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### hw/rtl/gapf_pkg.sv
// ----------------------------------------------------------------------------
// gapf_pkg
// Types, constants and helpers shared by the grid path finder modules.
// ----------------------------------------------------------------------------
package gapf_pkg;

    localparam int MAX_COLUMNS = 8;
    localparam int MAX_ROWS    = 8;
    localparam int COORD_W     = 3;
    localparam int CELL_W      = 2 * COORD_W;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int DIM_W       = 4;
    localparam int WALL_W      = 4;
    localparam int COST_W      = 7;
    localparam int LEN_W       = CELL_W + 1;
    localparam int KEY_W       = COST_W + CELL_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_WAYPOINT    = 2'd0,
        ST_NO_PATH     = 2'd1,
        ST_OUT_OF_GRID = 2'd2,
        ST_OVERFLOW    = 2'd3
    } status_t;

    typedef struct packed
    {
        logic [0:0]         command;
        logic [CELL_W-1:0]  cell_index;
        logic [WALL_W-1:0]  wall_bits;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_z;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_z;
    } in_item_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_z;
        status_t            status;
        logic               last;
    } out_item_t;

    // classified item handed from front to back; cells coded as {z, x}
    typedef struct packed
    {
        logic               is_query;
        logic               bad;
        logic [CELL_W-1:0]  wall_addr;
        logic [WALL_W-1:0]  wall_bits;
        logic [CELL_W-1:0]  start_cell;
        logic [CELL_W-1:0]  goal_cell;
        logic [COST_W-1:0]  start_h;
    } desc_t;

    typedef enum logic [4:0]
    {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_REM_RD,
        S_REM_WR,
        S_CLOSE,
        S_EXP_RD,
        S_EXP_LAT,
        S_NB_RD,
        S_NB_CHK,
        S_FINISH,
        S_WALK,
        S_WALK_WR,
        S_EMIT_START,
        S_RT_RD,
        S_RT_GET,
        S_RT_STEP,
        S_EMIT_GOAL,
        S_STATUS
    } back_state_t;

    typedef enum logic [1:0]
    {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### hw/rtl/gapf_ram.sv
// ----------------------------------------------------------------------------
// gapf_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gapf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/gapf_front.sv
// ----------------------------------------------------------------------------
// gapf_front
// Classifies input words: range-checks queries, codes cells, start heuristic.
// ----------------------------------------------------------------------------
module gapf_front
    import gapf_pkg::*;
(
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    input  logic [DIM_W-1:0] columns_cfg,
    input  logic [DIM_W-1:0] rows_cfg,
    output logic             push_valid,
    input  logic             push_ready,
    output desc_t            push_data
);

    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic             out_of_grid;

    always_comb
    begin
        cols = eff_dim(columns_cfg, DIM_W'(MAX_COLUMNS));
        rows = eff_dim(rows_cfg, DIM_W'(MAX_ROWS));
        out_of_grid = (cols == '0) || (rows == '0)
                   || ({1'b0, in_data.start_x} >= cols) || ({1'b0, in_data.goal_x} >= cols)
                   || ({1'b0, in_data.start_z} >= rows) || ({1'b0, in_data.goal_z} >= rows);

        push_data.is_query   = (cmd_t'(in_data.command) == CMD_QUERY);
        push_data.bad        = out_of_grid;
        push_data.wall_addr  = in_data.cell_index;
        push_data.wall_bits  = in_data.wall_bits;
        push_data.start_cell = {in_data.start_z, in_data.start_x};
        push_data.goal_cell  = {in_data.goal_z, in_data.goal_x};
        push_data.start_h    = COST_W'(abs_diff(in_data.start_x, in_data.goal_x))
                             + COST_W'(abs_diff(in_data.start_z, in_data.goal_z));
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

### hw/rtl/gapf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gapf_cmd_fifo
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module gapf_cmd_fifo
    import gapf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  desc_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output desc_t rd_data
);

    desc_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/gapf_back.sv
// ----------------------------------------------------------------------------
// gapf_back
// Search engine: wall loads, A* over the grid, route walk and waypoint output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gapf_back
    import gapf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] columns_cfg,
    input  logic [DIM_W-1:0] rows_cfg,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  desc_t            cmd_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    back_state_t       state_reg, state_next;
    logic [QC_W-1:0]   q_count_reg, q_count_next;
    logic [QC_W-1:0]   scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [QA_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [QA_W-1:0]   best_idx_reg, best_idx_next;
    logic              best_set_reg, best_set_next;
    logic [CELL_W-1:0] cur_reg, cur_next;
    logic [COST_W-1:0] cur_cost_reg, cur_cost_next;
    logic [WALL_W-1:0] cur_walls_reg, cur_walls_next;
    dir_t              dir_reg, dir_next;
    logic [CELL_W-1:0] nb_reg, nb_next;
    logic [CELL_W-1:0] start_reg, start_next;
    logic [CELL_W-1:0] goal_reg, goal_next;
    logic [CELLS-1:0]  known_reg, known_next;
    logic [CELLS-1:0]  parent_v_reg, parent_v_next;
    logic [CELLS-1:0]  closed_reg, closed_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CELL_W-1:0] walk_reg, walk_next;
    logic [CELL_W-1:0] rt_idx_reg, rt_idx_next;
    logic              rt_first_reg, rt_first_next;
    logic [CELL_W-1:0] prev1_reg, prev1_next;
    logic [CELL_W-1:0] prev2_reg, prev2_next;
    logic [CELL_W-1:0] rt_cur_reg, rt_cur_next;
    status_t           status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    // ram ports
    logic              wall_we;
    logic [CELL_W-1:0] wall_waddr, wall_raddr;
    logic [WALL_W-1:0] wall_wdata, wall_rdata;
    logic              cost_we;
    logic [CELL_W-1:0] cost_waddr, cost_raddr;
    logic [COST_W-1:0] cost_wdata, cost_rdata;
    logic              par_we;
    logic [CELL_W-1:0] par_waddr, par_raddr;
    logic [CELL_W-1:0] par_wdata, par_rdata;
    logic              q_we;
    logic [QA_W-1:0]   q_waddr, q_raddr;
    logic [KEY_W-1:0]  q_wdata, q_rdata;
    logic              rt_we;
    logic [CELL_W-1:0] rt_waddr, rt_raddr;
    logic [CELL_W-1:0] rt_wdata, rt_rdata;

    logic [DIM_W-1:0]   cols;
    logic [DIM_W-1:0]   rows;
    logic [LEN_W-1:0]   n_cells;
    logic [COORD_W-1:0] cx, cz;
    logic [COORD_W-1:0] nx, nz;
    logic               nb_ok;
    logic [COST_W-1:0]  new_cost;
    logic [COST_W-1:0]  nb_prio;
    logic               out_free;
    logic               turn;
    logic               nb_step_last;

    always_comb
    begin
        cols     = eff_dim(columns_cfg, DIM_W'(MAX_COLUMNS));
        rows     = eff_dim(rows_cfg, DIM_W'(MAX_ROWS));
        n_cells  = LEN_W'({3'b000, cols} * {3'b000, rows});
        cx       = cur_reg[COORD_W-1:0];
        cz       = cur_reg[CELL_W-1:COORD_W];
        out_free = !out_valid_reg || out_ready;
        new_cost = cur_cost_reg + COST_W'(1);
        nb_prio  = new_cost
                 + COST_W'(abs_diff(nb_reg[COORD_W-1:0], goal_reg[COORD_W-1:0]))
                 + COST_W'(abs_diff(nb_reg[CELL_W-1:COORD_W], goal_reg[CELL_W-1:COORD_W]));
        turn     = (prev1_reg - prev2_reg) != (rt_cur_reg - prev1_reg);
        nb_step_last = (dir_reg == DIR_WEST);

        nx = cx;
        nz = cz;
        nb_ok = 1'b0;
        unique case (dir_reg)
            DIR_NORTH:
            begin
                nz    = cz - COORD_W'(1);
                nb_ok = (cz != '0);
            end
            DIR_EAST:
            begin
                nx    = cx + COORD_W'(1);
                nb_ok = (({1'b0, cx} + DIM_W'(1)) < cols);
            end
            DIR_SOUTH:
            begin
                nz    = cz + COORD_W'(1);
                nb_ok = (({1'b0, cz} + DIM_W'(1)) < rows);
            end
            DIR_WEST:
            begin
                nx    = cx - COORD_W'(1);
                nb_ok = (cx != '0);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
        nb_ok = nb_ok && !cur_walls_reg[dir_reg] && !closed_reg[{nz, nx}];
    end

    always_comb
    begin
        state_next     = state_reg;
        q_count_next   = q_count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        best_key_next  = best_key_reg;
        best_idx_next  = best_idx_reg;
        best_set_next  = best_set_reg;
        cur_next       = cur_reg;
        cur_cost_next  = cur_cost_reg;
        cur_walls_next = cur_walls_reg;
        dir_next       = dir_reg;
        nb_next        = nb_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        known_next     = known_reg;
        parent_v_next  = parent_v_reg;
        closed_next    = closed_reg;
        len_next       = len_reg;
        walk_next      = walk_reg;
        rt_idx_next    = rt_idx_reg;
        rt_first_next  = rt_first_reg;
        prev1_next     = prev1_reg;
        prev2_next     = prev2_reg;
        rt_cur_next    = rt_cur_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        cmd_ready      = 1'b0;

        wall_we    = 1'b0;
        wall_waddr = cmd_data.wall_addr;
        wall_wdata = cmd_data.wall_bits;
        wall_raddr = CELL_W'({4'b0000, cz} * {3'b000, cols} + {4'b0000, cx});
        cost_we    = 1'b0;
        cost_waddr = nb_reg;
        cost_wdata = new_cost;
        cost_raddr = cur_reg;
        par_we     = 1'b0;
        par_waddr  = nb_reg;
        par_wdata  = cur_reg;
        par_raddr  = walk_reg;
        q_we       = 1'b0;
        q_waddr    = q_count_reg[QA_W-1:0];
        q_wdata    = {nb_prio, nb_reg};
        q_raddr    = scan_idx_reg[QA_W-1:0];
        rt_we      = 1'b0;
        rt_waddr   = len_reg[CELL_W-1:0];
        rt_wdata   = par_rdata;
        rt_raddr   = rt_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (!cmd_data.is_query)
                    begin
                        wall_we = 1'b1;
                    end
                    else if (cmd_data.bad)
                    begin
                        status_next = ST_OUT_OF_GRID;
                        state_next  = S_STATUS;
                    end
                    else
                    begin
                        start_next    = cmd_data.start_cell;
                        goal_next     = cmd_data.goal_cell;
                        known_next    = '0;
                        known_next[cmd_data.start_cell] = 1'b1;
                        parent_v_next = '0;
                        closed_next   = '0;
                        cost_we       = 1'b1;
                        cost_waddr    = cmd_data.start_cell;
                        cost_wdata    = '0;
                        q_we          = 1'b1;
                        q_waddr       = '0;
                        q_wdata       = {cmd_data.start_h, cmd_data.start_cell};
                        q_count_next  = QC_W'(1);
                        state_next    = S_POP;
                    end
                end
            end
            S_POP:
            begin
                scan_idx_next = '0;
                pend_next     = 1'b0;
                best_set_next = 1'b0;
                state_next    = (q_count_reg == '0) ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                // one queue read per cycle, compared in the next cycle
                if (pend_reg && (!best_set_reg || (q_rdata < best_key_reg)))
                begin
                    best_key_next = q_rdata;
                    best_idx_next = pend_addr_reg;
                    best_set_next = 1'b1;
                end
                if (scan_idx_reg < q_count_reg)
                begin
                    q_raddr        = scan_idx_reg[QA_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = scan_idx_reg[QA_W-1:0];
                    scan_idx_next  = scan_idx_reg + QC_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_REM_RD;
                    end
                end
            end
            S_REM_RD:
            begin
                q_raddr    = QA_W'(q_count_reg - QC_W'(1));
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                // tail entry fills the hole left by the minimum
                q_we         = 1'b1;
                q_waddr      = best_idx_reg;
                q_wdata      = q_rdata;
                q_count_next = q_count_reg - QC_W'(1);
                cur_next     = best_key_reg[CELL_W-1:0];
                state_next   = S_CLOSE;
            end
            S_CLOSE:
            begin
                if (closed_reg[cur_reg])
                begin
                    state_next = S_POP;
                end
                else
                begin
                    closed_next[cur_reg] = 1'b1;
                    state_next = (cur_reg == goal_reg) ? S_FINISH : S_EXP_RD;
                end
            end
            S_EXP_RD:
            begin
                state_next = S_EXP_LAT;
            end
            S_EXP_LAT:
            begin
                cur_walls_next = wall_rdata;
                cur_cost_next  = cost_rdata;
                dir_next       = DIR_NORTH;
                state_next     = S_NB_RD;
            end
            S_NB_RD:
            begin
                if (nb_ok)
                begin
                    nb_next    = {nz, nx};
                    cost_raddr = {nz, nx};
                    state_next = S_NB_CHK;
                end
                else if (nb_step_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            S_NB_CHK:
            begin
                if (known_reg[nb_reg] && (new_cost >= cost_rdata))
                begin
                    state_next = nb_step_last ? S_POP : S_NB_RD;
                    dir_next   = dir_t'(dir_reg + 2'd1);
                end
                else if (q_count_reg >= QC_W'(QUEUE_DEPTH))
                begin
                    status_next = ST_OVERFLOW;
                    state_next  = S_STATUS;
                end
                else
                begin
                    cost_we               = 1'b1;
                    par_we                = 1'b1;
                    known_next[nb_reg]    = 1'b1;
                    parent_v_next[nb_reg] = 1'b1;
                    q_we                  = 1'b1;
                    q_count_next          = q_count_reg + QC_W'(1);
                    state_next            = nb_step_last ? S_POP : S_NB_RD;
                    dir_next              = dir_t'(dir_reg + 2'd1);
                end
            end
            S_FINISH:
            begin
                if ((goal_reg != start_reg) && !parent_v_reg[goal_reg])
                begin
                    status_next = ST_NO_PATH;
                    state_next  = S_STATUS;
                end
                else
                begin
                    rt_we      = 1'b1;
                    rt_waddr   = '0;
                    rt_wdata   = goal_reg;
                    walk_next  = goal_reg;
                    len_next   = LEN_W'(1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_reg == start_reg)
                begin
                    state_next = S_EMIT_START;
                end
                else if (!parent_v_reg[walk_reg] || (len_reg >= n_cells))
                begin
                    status_next = ST_NO_PATH;
                    state_next  = S_STATUS;
                end
                else
                begin
                    state_next = S_WALK_WR;
                end
            end
            S_WALK_WR:
            begin
                rt_we      = 1'b1;
                walk_next  = par_rdata;
                len_next   = len_reg + LEN_W'(1);
                state_next = S_WALK;
            end
            S_EMIT_START:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.point_x = start_reg[COORD_W-1:0];
                    out_data_next.point_z = start_reg[CELL_W-1:COORD_W];
                    out_data_next.status  = ST_WAYPOINT;
                    out_data_next.last    = (len_reg == LEN_W'(1));
                    rt_idx_next           = CELL_W'(len_reg - LEN_W'(2));
                    rt_first_next         = 1'b1;
                    prev2_next            = start_reg;
                    state_next            = (len_reg == LEN_W'(1)) ? S_IDLE : S_RT_RD;
                end
            end
            S_RT_RD:
            begin
                state_next = S_RT_GET;
            end
            S_RT_GET:
            begin
                rt_cur_next = rt_rdata;
                state_next  = S_RT_STEP;
            end
            S_RT_STEP:
            begin
                if (rt_first_reg || !turn || out_free)
                begin
                    if (!rt_first_reg && turn)
                    begin
                        out_valid_next        = 1'b1;
                        out_data_next.point_x = prev1_reg[COORD_W-1:0];
                        out_data_next.point_z = prev1_reg[CELL_W-1:COORD_W];
                        out_data_next.status  = ST_WAYPOINT;
                        out_data_next.last    = 1'b0;
                    end
                    if (!rt_first_reg)
                    begin
                        prev2_next = prev1_reg;
                    end
                    rt_first_next = 1'b0;
                    prev1_next    = rt_cur_reg;
                    if (rt_idx_reg == '0)
                    begin
                        state_next = S_EMIT_GOAL;
                    end
                    else
                    begin
                        rt_idx_next = rt_idx_reg - CELL_W'(1);
                        state_next  = S_RT_RD;
                    end
                end
            end
            S_EMIT_GOAL:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.point_x = goal_reg[COORD_W-1:0];
                    out_data_next.point_z = goal_reg[CELL_W-1:COORD_W];
                    out_data_next.status  = ST_WAYPOINT;
                    out_data_next.last    = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.point_x = '0;
                    out_data_next.point_z = '0;
                    out_data_next.status  = status_reg;
                    out_data_next.last    = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            q_count_reg   <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            best_set_reg  <= 1'b0;
            dir_reg       <= DIR_NORTH;
            known_reg     <= '0;
            parent_v_reg  <= '0;
            closed_reg    <= '0;
            len_reg       <= '0;
            rt_first_reg  <= 1'b0;
            status_reg    <= ST_WAYPOINT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_count_reg   <= q_count_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            best_set_reg  <= best_set_next;
            dir_reg       <= dir_next;
            known_reg     <= known_next;
            parent_v_reg  <= parent_v_next;
            closed_reg    <= closed_next;
            len_reg       <= len_next;
            rt_first_reg  <= rt_first_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        best_key_reg  <= best_key_next;
        best_idx_reg  <= best_idx_next;
        cur_reg       <= cur_next;
        cur_cost_reg  <= cur_cost_next;
        cur_walls_reg <= cur_walls_next;
        nb_reg        <= nb_next;
        start_reg     <= start_next;
        goal_reg      <= goal_next;
        walk_reg      <= walk_next;
        rt_idx_reg    <= rt_idx_next;
        prev1_reg     <= prev1_next;
        prev2_reg     <= prev2_next;
        rt_cur_reg    <= rt_cur_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    gapf_ram #(.WIDTH(WALL_W), .DEPTH(CELLS)) u_wall_ram (
        .clk   (clk),
        .we    (wall_we),
        .waddr (wall_waddr),
        .wdata (wall_wdata),
        .raddr (wall_raddr),
        .rdata (wall_rdata)
    );

    gapf_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    gapf_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    gapf_ram #(.WIDTH(KEY_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    gapf_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_route_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (rt_raddr),
        .rdata (rt_rdata)
    );

    `ASSERT_ALWAYS(a_queue_bound, q_count_reg <= QC_W'(QUEUE_DEPTH), "open queue count past depth")
    `ASSERT_NEXT(a_close_marks, (state_reg == S_CLOSE) && !closed_reg[cur_reg], closed_reg[cur_reg], "popped cell not closed")
    `ASSERT_ALWAYS(a_route_len, (state_reg == S_WALK_WR) |-> (len_reg < LEN_W'(CELLS)), "route walk past grid size")

endmodule

### hw/rtl/grid_astar_path_finder_top.sv
// loads: taken by the back end from the two-word command queue while it is idle
// queries: set up when accepted, then each pop scans the open queue linearly for the minimum and
// moves the tail entry into its slot, and the popped cell is then expanded neighbor by neighbor
// route: walked back from the goal through the parent store, then emitted one word at a time
// reset (async, active low): grid 8 x 8, queues empty; wall store not cleared
// ----------------------------------------------------------------------------
// grid_astar_path_finder_top
// Grid A* path finder: wall loads, queries, waypoint words on the output.
// ----------------------------------------------------------------------------
module grid_astar_path_finder_top
    import gapf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    logic [DIM_W-1:0] columns_reg, columns_next;
    logic [DIM_W-1:0] rows_reg, rows_next;
    logic             push_valid, push_ready;
    desc_t            push_data;
    logic             cmd_valid, cmd_ready;
    desc_t            cmd_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: columns_next = cfg_data;
                CFG_ROWS:    rows_next    = cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= DIM_W'(MAX_COLUMNS);
            rows_reg    <= DIM_W'(MAX_ROWS);
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    gapf_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .columns_cfg (columns_reg),
        .rows_cfg    (rows_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    gapf_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (cmd_valid),
        .rd_ready (cmd_ready),
        .rd_data  (cmd_data)
    );

    gapf_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .columns_cfg (columns_reg),
        .rows_cfg    (rows_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
